// File: rtl/point_in_polygon_crossing_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-polygon crossing core
// Clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_CROSSING_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_CROSSING_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PIP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pip: same-cycle check failed");

// antecedent implies consequent in the following cycle
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pip: next-cycle check failed");

`endif

// File: rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared widths, register indexes, request and response types of the crossing core.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_W    = 32;
    localparam int COUNT_W    = 13;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int MD_CNT_W   = $clog2(COORD_W);

    localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_X = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_Y = 1'd1;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      last_vertex;
    } t_pip_in_req;

    typedef struct packed {
        logic               inside_res;
        logic [COUNT_W-1:0] crossing_count;
    } t_pip_out_req;

    typedef struct packed {
        logic               go;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
    } t_edge_req;

    typedef struct packed {
        logic done;
        logic hit;
    } t_edge_rsp;

endpackage

// File: rtl/point_in_polygon_crossing_core.sv
// Rate: one vertex request at a time; the input stalls while its edges run.
// An edge that misses the query row, or is flat, ends in E_SPAN; one that spans it
// also runs the bit-serial unit (32 multiply steps then 32 divide steps) and E_FIN.
// A vertex that opens a polygon needs no edge test; any other waits for its edge.
// After the last vertex the closing edge runs; S_OUT then waits for a free output.
// Reset (synchronous, active low) clears the query registers, polygon state and count.
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_core
// Even-odd ray casting over a stream of vertices; emits count and parity.
// ----------------------------------------------------------------------------
`include "point_in_polygon_crossing_core_assert.svh"

module point_in_polygon_crossing_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pip_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [pip_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pip_pkg::t_pip_in_req           i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pip_pkg::t_pip_out_req          o_out_data
);

    localparam int W = pip_pkg::COORD_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_E1   = 2'd1;
    localparam logic [1:0] S_E2   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                  r_state;
    logic                        r_have_prev;
    logic                        r_edge_go;
    logic                        r_out_valid;
    logic [pip_pkg::COUNT_W-1:0] r_count;
    logic [W-1:0]                r_qx;
    logic [W-1:0]                r_qy;
    logic [W-1:0]                r_first_x;
    logic [W-1:0]                r_first_y;
    logic [W-1:0]                r_prev_x;
    logic [W-1:0]                r_prev_y;
    logic [W-1:0]                r_vx;
    logic [W-1:0]                r_vy;
    logic                        r_last;
    pip_pkg::t_pip_out_req       r_out;

    logic                        w_in_acc;
    logic                        w_out_free;
    pip_pkg::t_edge_req          w_edge_req;
    pip_pkg::t_edge_rsp          w_edge_rsp;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign w_edge_req.go = r_edge_go;
    assign w_edge_req.ax = (r_state == S_E1) ? r_prev_x : r_first_x;
    assign w_edge_req.ay = (r_state == S_E1) ? r_prev_y : r_first_y;
    assign w_edge_req.bx = r_vx;
    assign w_edge_req.by = r_vy;

    pip_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_edge_req),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_rsp   (w_edge_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pip_pkg::CFG_QUERY_X: r_qx <= i_cfg_data;
                pip_pkg::CFG_QUERY_Y: r_qy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_edge_go   <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            r_edge_go <= ((r_state == S_IDLE) && w_in_acc
                          && (r_have_prev || i_in_data.last_vertex))
                         || ((r_state == S_E1) && w_edge_rsp.done && r_last);
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (r_have_prev) begin
                            r_state <= S_E1;
                        end else begin
                            r_first_x   <= i_in_data.vertex_x;
                            r_first_y   <= i_in_data.vertex_y;
                            r_prev_x    <= i_in_data.vertex_x;
                            r_prev_y    <= i_in_data.vertex_y;
                            r_count     <= '0;
                            r_have_prev <= 1'b1;
                            if (i_in_data.last_vertex) begin
                                r_state <= S_E2;
                            end
                        end
                    end
                end
                S_E1: begin
                    if (w_edge_rsp.done) begin
                        r_count  <= r_count + {{(pip_pkg::COUNT_W-1){1'b0}}, w_edge_rsp.hit};
                        r_prev_x <= r_vx;
                        r_prev_y <= r_vy;
                        if (r_last) begin
                            r_state <= S_E2;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_E2: begin
                    if (w_edge_rsp.done) begin
                        r_count <= r_count + {{(pip_pkg::COUNT_W-1){1'b0}}, w_edge_rsp.hit};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_have_prev <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_vx   <= i_in_data.vertex_x;
            r_vy   <= i_in_data.vertex_y;
            r_last <= i_in_data.last_vertex;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out.inside_res     <= r_count[0];
            r_out.crossing_count <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PIP_ASSERT_NEXT(a_emit_closes_polygon, i_clk, i_rst_n, (r_state == S_OUT) && w_out_free, o_out_valid && (r_state == S_IDLE) && !r_have_prev)
    `PIP_ASSERT_NOW(a_edge_rsp_when_waiting, i_clk, i_rst_n, w_edge_rsp.done, (r_state == S_E1) || (r_state == S_E2))
    `PIP_ASSERT_NEXT(a_first_vertex_opens, i_clk, i_rst_n, w_in_acc && !r_have_prev, r_have_prev && (r_count == '0))

endmodule

// File: rtl/pip_muldiv.sv
// ----------------------------------------------------------------------------
// pip_muldiv
// Bit-serial shift-add multiply then restoring divide: quot = up * adx / dy.
// ----------------------------------------------------------------------------
module pip_muldiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [pip_pkg::COORD_W-1:0]   i_up,
    input  logic [pip_pkg::COORD_W-1:0]   i_adx,
    input  logic [pip_pkg::COORD_W-1:0]   i_dy,
    output logic                          o_done,
    output logic [pip_pkg::COORD_W-1:0]   o_quot
);

    localparam int W = pip_pkg::COORD_W;
    localparam logic [pip_pkg::MD_CNT_W-1:0] LAST_STEP = pip_pkg::MD_CNT_W'(W - 1);

    logic                         r_busy;
    logic                         r_div;
    logic                         r_done;
    logic [pip_pkg::MD_CNT_W-1:0] r_cnt;
    logic [W-1:0]                 r_hi;
    logic [W-1:0]                 r_lo;
    logic [W-1:0]                 r_adx;
    logic [W-1:0]                 r_dy;

    logic [W:0]   w_sum;
    logic [W:0]   w_rem;
    logic [W+1:0] w_diff;
    logic         w_ge;

    assign w_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_adx} : '0);
    assign w_rem  = {r_hi, r_lo[W-1]};
    assign w_diff = {1'b0, w_rem} - {2'b00, r_dy};
    assign w_ge   = ~w_diff[W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_go && r_busy && r_div && (r_cnt == LAST_STEP);
            if (i_go) begin
                r_busy <= 1'b1;
                r_div  <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                // counter wraps to zero after the last step of each pass
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    if (r_div) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_div <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_hi  <= '0;
            r_lo  <= i_up;
            r_adx <= i_adx;
            r_dy  <= i_dy;
        end else if (r_busy) begin
            if (r_div) begin
                r_hi <= w_ge ? w_diff[W-1:0] : w_rem[W-1:0];
                r_lo <= {r_lo[W-2:0], w_ge};
            end else begin
                r_hi <= w_sum[W:1];
                r_lo <= {w_sum[0], r_lo[W-1:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lo;

endmodule

// File: rtl/pip_edge.sv
// ----------------------------------------------------------------------------
// pip_edge
// Tests one polygon edge against the leftward ray from the query point.
// ----------------------------------------------------------------------------
module pip_edge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pip_pkg::t_edge_req          i_req,
    input  logic [pip_pkg::COORD_W-1:0] i_qx,
    input  logic [pip_pkg::COORD_W-1:0] i_qy,
    output pip_pkg::t_edge_rsp          o_rsp
);

    localparam int W = pip_pkg::COORD_W;

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_ROW  = 3'd1;
    localparam logic [2:0] E_SPAN = 3'd2;
    localparam logic [2:0] E_RUN  = 3'd3;
    localparam logic [2:0] E_FIN  = 3'd4;

    logic [2:0]   r_state;
    logic         r_done;
    logic         r_cross;
    logic         r_neg;
    logic [W-1:0] r_lo_x;
    logic [W-1:0] r_lo_y;
    logic [W-1:0] r_hi_x;
    logic [W-1:0] r_hi_y;
    logic [W:0]   r_row;
    logic [W-1:0] r_q;

    logic         w_swap;
    logic         w_on_row;
    logic [W:0]   w_lo_y;
    logic [W:0]   w_hi_y;
    logic         w_skip;
    logic         w_flat;
    logic [W:0]   w_up;
    logic [W:0]   w_dx;
    logic [W:0]   w_ndx;
    logic [W-1:0] w_adx;
    logic [W-1:0] w_dy;
    logic         w_md_go;
    logic         w_md_done;
    logic [W-1:0] w_md_quot;
    logic [W+1:0] w_ix;
    logic [W+1:0] w_qx;

    assign w_swap   = $signed(i_req.ay) > $signed(i_req.by);
    assign w_on_row = (r_hi_y == i_qy) || (r_lo_y == i_qy);
    assign w_lo_y   = {r_lo_y[W-1], r_lo_y};
    assign w_hi_y   = {r_hi_y[W-1], r_hi_y};
    assign w_skip   = ($signed(w_lo_y) > $signed(r_row)) || ($signed(w_hi_y) < $signed(r_row));
    assign w_flat   = (r_lo_y == r_hi_y);
    assign w_up     = w_hi_y - r_row;
    assign w_dy     = r_hi_y - r_lo_y;
    assign w_dx     = {r_hi_x[W-1], r_hi_x} - {r_lo_x[W-1], r_lo_x};
    assign w_ndx    = -w_dx;
    assign w_adx    = w_dx[W] ? w_ndx[W-1:0] : w_dx[W-1:0];
    assign w_md_go  = (r_state == E_SPAN) && !w_skip && !w_flat;
    assign w_qx     = {{2{i_qx[W-1]}}, i_qx};
    assign w_ix     = {{2{r_hi_x[W-1]}}, r_hi_x} + (r_neg ? {2'b00, r_q} : -{2'b00, r_q});

    pip_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_md_go),
        .i_up    (w_up[W-1:0]),
        .i_adx   (w_adx),
        .i_dy    (w_dy),
        .o_done  (w_md_done),
        .o_quot  (w_md_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= ((r_state == E_SPAN) && (w_skip || w_flat)) || (r_state == E_FIN);
            unique case (r_state)
                E_IDLE: begin
                    if (i_req.go) begin
                        r_state <= E_ROW;
                    end
                end
                E_ROW: begin
                    r_state <= E_SPAN;
                end
                E_SPAN: begin
                    if (w_skip || w_flat) begin
                        r_state <= E_IDLE;
                    end else begin
                        r_state <= E_RUN;
                    end
                end
                E_RUN: begin
                    if (w_md_done) begin
                        r_state <= E_FIN;
                    end
                end
                E_FIN: begin
                    r_state <= E_IDLE;
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == E_IDLE && i_req.go) begin
            r_lo_x <= w_swap ? i_req.bx : i_req.ax;
            r_lo_y <= w_swap ? i_req.by : i_req.ay;
            r_hi_x <= w_swap ? i_req.ax : i_req.bx;
            r_hi_y <= w_swap ? i_req.ay : i_req.by;
        end
        if (r_state == E_ROW) begin
            r_row <= {i_qy[W-1], i_qy} - {{W{1'b0}}, w_on_row};
        end
        if (r_state == E_SPAN) begin
            r_neg   <= w_dx[W];
            r_cross <= !w_skip && ($signed(r_hi_x) < $signed(i_qx));
        end
        if (r_state == E_RUN && w_md_done) begin
            r_q <= w_md_quot;
        end
        if (r_state == E_FIN) begin
            r_cross <= $signed(w_ix) < $signed(w_qx);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hit  = r_cross;

endmodule
